@@ rtl/core/mrcm_pkg.sv @@
package mrcm_pkg;

	localparam int CODE_COUNT   = 21;
	localparam int LINE_W       = 6;
	localparam int MAX_LINE_DEF = 40;
	localparam int TEXT_W       = 96;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	localparam logic [1:0] OUT_CONNECTED = 2'd0;
	localparam logic [1:0] OUT_ERROR     = 2'd1;
	localparam logic [1:0] OUT_NONE      = 2'd2;

	localparam logic [2:0] REPLY_ERR = 3'd7;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;

	localparam logic [3:0] TIMEOUT_RESET = 4'd4;

	// text right-justified: last character in the low byte
	localparam logic [TEXT_W-1:0] CODE_TEXT [CODE_COUNT] = '{
		TEXT_W'("CONNECT"), TEXT_W'("1"),
		TEXT_W'("CONNECT 1200"), TEXT_W'("5"), TEXT_W'("15"),
		TEXT_W'("CONNECT 2400"), TEXT_W'("10"), TEXT_W'("16"),
		TEXT_W'("CONNECT 9600"), TEXT_W'("13"), TEXT_W'("17"),
		TEXT_W'("NO CARRIER"), TEXT_W'("3"),
		TEXT_W'("ERROR"), TEXT_W'("4"),
		TEXT_W'("NO DIALTONE"), TEXT_W'("6"),
		TEXT_W'("BUSY"), TEXT_W'("7"),
		TEXT_W'("NO ANSWER"), TEXT_W'("8")
	};

	localparam logic [3:0] CODE_LEN [CODE_COUNT] = '{
		4'd7, 4'd1, 4'd12, 4'd1, 4'd2, 4'd12, 4'd2, 4'd2, 4'd12, 4'd2, 4'd2,
		4'd10, 4'd1, 4'd5, 4'd1, 4'd11, 4'd1, 4'd4, 4'd1, 4'd9, 4'd1
	};

	// rate code for connect entries, REPLY_ERR for failure entries
	localparam logic [2:0] CODE_REPLY [CODE_COUNT] = '{
		3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4,
		REPLY_ERR, REPLY_ERR, REPLY_ERR, REPLY_ERR, REPLY_ERR,
		REPLY_ERR, REPLY_ERR, REPLY_ERR, REPLY_ERR, REPLY_ERR
	};

	typedef struct packed {
		logic       hit;
		logic [1:0] outcome;
		logic [2:0] baud;
	} result_t;

	function automatic logic [CODE_COUNT-1:0] length_mask(input logic [LINE_W-1:0] n);
		logic [CODE_COUNT-1:0] m;
		m = '0;
		for (int i = 0; i < CODE_COUNT; i++) begin
			m[i] = ({2'b00, CODE_LEN[i]} == n);
		end
		return m;
	endfunction

	// character at position pos (pos below the entry length)
	function automatic logic [7:0] code_char(input int unsigned idx, input logic [3:0] pos);
		logic [3:0] off;
		off = CODE_LEN[idx] - pos - 4'd1;
		return CODE_TEXT[idx][{off, 3'b000} +: 8];
	endfunction

endpackage

@@ rtl/core/modem_result_code_matcher.sv @@
// Flow: a transaction accepted on the slave side is held in the input register and matched
//   there; its result, if any, is registered into the output register when the input advances.
// Throughput: one transaction per cycle; the input register and the match logic advance
//   whenever the output register is empty or being read.
// Reset: arst_n clears both registers' valid flags and the line state; timeout is 4 s.
module modem_result_code_matcher #(
	parameter int MAX_LINE = mrcm_pkg::MAX_LINE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [1:0] outcome, [4:2] baud_index, [7:5] zero
);
	import mrcm_pkg::*;

	logic [3:0] timeout_q;
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       m_tvalid_q;
	logic [4:0] m_data_q;
	result_t    res;

	assign pready = 1'b1;
	assign prdata = {28'd0, timeout_q};

	// single register at byte address 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_TIMEOUT) begin
			timeout_q <= pwdata[3:0];
		end
	end

	assign advance = valid_s1 & (~m_tvalid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	mrcm_core #(
		.MAX_LINE(MAX_LINE)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.kind(kind_s1),
		.byte_value(byte_s1),
		.timeout_seconds(timeout_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= res.hit;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			m_data_q <= {res.baud, res.outcome};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {3'd0, m_data_q};

endmodule

@@ rtl/core/mrcm_core.sv @@
module mrcm_core #(
	parameter int MAX_LINE = mrcm_pkg::MAX_LINE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           kind,
	input  logic [7:0]           byte_value,
	input  logic [3:0]           timeout_seconds,
	output mrcm_pkg::result_t    res
);
	import mrcm_pkg::*;

	logic [LINE_W-1:0]     line_len_q, line_len_n, len_inc;
	logic [CODE_COUNT-1:0] flags_q, flags_n, hits;
	logic                  ended_q, ended_n;
	logic [3:0]            sec_q, sec_n, sec_inc;
	logic [7:0]            upper;
	logic [4:0]            sel;
	logic                  found;
	logic                  clear;

	always_comb begin
		upper = (byte_value >= 8'h61 && byte_value <= 8'h7a) ? byte_value - 8'd32 : byte_value;
		len_inc = line_len_q + 1'b1;
		sec_inc = (sec_q == 4'hf) ? sec_q : sec_q + 4'd1;
		hits = flags_q & (ended_q ? {CODE_COUNT{1'b1}} : length_mask(line_len_q));
		found = 1'b0;
		sel = '0;
		for (int i = CODE_COUNT - 1; i >= 0; i--) begin
			if (hits[i]) begin
				found = 1'b1;
				sel = 5'(i);
			end
		end

		line_len_n = line_len_q;
		flags_n = flags_q;
		ended_n = ended_q;
		sec_n = sec_q;
		clear = 1'b0;
		res = '0;

		case (kind)
			KIND_ABORT: begin
				res.hit = 1'b1;
				res.outcome = OUT_NONE;
				clear = 1'b1;
			end
			KIND_TICK: begin
				sec_n = sec_inc;
				if (sec_inc >= timeout_seconds) begin
					res.hit = 1'b1;
					res.outcome = OUT_NONE;
					clear = 1'b1;
				end
			end
			KIND_BYTE: begin
				if (byte_value == CHAR_CR || byte_value == CHAR_LF) begin
					clear = 1'b1;
					if (found) begin
						res.hit = 1'b1;
						if (CODE_REPLY[sel] == REPLY_ERR) begin
							res.outcome = OUT_ERROR;
						end else begin
							res.outcome = OUT_CONNECTED;
							res.baud = CODE_REPLY[sel];
						end
					end
				end else begin
					if (!ended_q) begin
						if (byte_value == 8'd0) begin
							flags_n = flags_q & length_mask(line_len_q);
							ended_n = 1'b1;
						end else begin
							for (int i = 0; i < CODE_COUNT; i++) begin
								if (!(line_len_q < {2'b00, CODE_LEN[i]} &&
										code_char(i, line_len_q[3:0]) == upper)) begin
									flags_n[i] = 1'b0;
								end
							end
						end
					end
					line_len_n = len_inc;
					if (len_inc >= LINE_W'(MAX_LINE)) begin
						res.hit = 1'b1;
						res.outcome = OUT_NONE;
						clear = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (clear) begin
			line_len_n = '0;
			flags_n = '1;
			ended_n = 1'b0;
			sec_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			flags_q <= '1;
			ended_q <= 1'b0;
			sec_q <= '0;
		end else if (step) begin
			line_len_q <= line_len_n;
			flags_q <= flags_n;
			ended_q <= ended_n;
			sec_q <= sec_n;
		end
	end

endmodule

@@ rtl/core/mrcm_checker.sv @@
module mrcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);
	import mrcm_pkg::*;

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> prdata[3:0] == $past(pwdata[3:0]))
		else $error("timeout register does not read back written value");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output side is free");

	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == OUT_CONNECTED || m_tdata[1:0] == OUT_ERROR ||
			m_tdata[1:0] == OUT_NONE) && m_tdata[4:2] != 3'd3 && m_tdata[4:2] <= 3'd4 &&
			(m_tdata[1:0] == OUT_CONNECTED || m_tdata[4:2] == 3'd0) && m_tdata[7:5] == 3'd0)
		else $error("inconsistent result fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind modem_result_code_matcher mrcm_checker u_mrcm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.pwdata(pwdata),
	.prdata(prdata),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
